FILE: rtl/foapf_pkg.sv
`default_nettype none
package foapf_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  localparam int ANGLE_W = 34;
  localparam int FREQ_W = 21;
  localparam int RATE_W = 18;
  localparam int GAIN_W = 16;
  localparam int ALPHA_W = 24;
  localparam int QUO_W = 26;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ANGLE,
    ST_CORDIC,
    ST_DIV_PREP,
    ST_DIV,
    ST_FB_MUL,
    ST_X_SAT,
    ST_Y_MUL,
    ST_Y_SAT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic angle_step;
    logic cordic_step;
    logic div_prep;
    logic div_step;
    logic fb_mul;
    logic x_sat;
    logic y_mul;
    logic y_sat;
  } cmd_t;

  typedef struct packed {
    logic angle_done;
    logic cordic_done;
    logic div_done;
  } status_t;

  function automatic logic [ANGLE_W-1:0] atan_q30(input logic [4:0] i);
    case (i)
      5'd0: atan_q30 = 34'd843314856;
      5'd1: atan_q30 = 34'd497837829;
      5'd2: atan_q30 = 34'd263043836;
      5'd3: atan_q30 = 34'd133525158;
      5'd4: atan_q30 = 34'd67021686;
      5'd5: atan_q30 = 34'd33543515;
      5'd6: atan_q30 = 34'd16775850;
      5'd7: atan_q30 = 34'd8388437;
      5'd8: atan_q30 = 34'd4194282;
      5'd9: atan_q30 = 34'd2097149;
      5'd10: atan_q30 = 34'd1048575;
      5'd11: atan_q30 = 34'd524287;
      5'd12: atan_q30 = 34'd262143;
      5'd13: atan_q30 = 34'd131071;
      5'd14: atan_q30 = 34'd65535;
      5'd15: atan_q30 = 34'd32767;
      5'd16: atan_q30 = 34'd16383;
      5'd17: atan_q30 = 34'd8191;
      5'd18: atan_q30 = 34'd4095;
      5'd19: atan_q30 = 34'd2047;
      5'd20: atan_q30 = 34'd1023;
      5'd21: atan_q30 = 34'd511;
      5'd22: atan_q30 = 34'd255;
      5'd23: atan_q30 = 34'd127;
      5'd24: atan_q30 = 34'd63;
      5'd25: atan_q30 = 34'd31;
      5'd26: atan_q30 = 34'd15;
      5'd27: atan_q30 = 34'd8;
      5'd28: atan_q30 = 34'd4;
      5'd29: atan_q30 = 34'd2;
      5'd30: atan_q30 = 34'd1;
      default: atan_q30 = 34'd0;
    endcase
  endfunction

endpackage
`default_nettype wire

FILE: rtl/foapf_ctrl.sv
`default_nettype none
module foapf_ctrl
  import foapf_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_fire,
  input  wire logic    out_fire,
  input  wire status_t status,
  output cmd_t         cmd,
  output logic         busy,
  output logic         out_valid
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = 1'b1;
    out_valid = 1'b0;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (in_fire) begin
          cmd.load = 1'b1;
          state_next = ST_ANGLE;
        end
      end
      ST_ANGLE: begin
        cmd.angle_step = 1'b1;
        if (status.angle_done) state_next = ST_CORDIC;
      end
      ST_CORDIC: begin
        cmd.cordic_step = 1'b1;
        if (status.cordic_done) state_next = ST_DIV_PREP;
      end
      ST_DIV_PREP: begin
        cmd.div_prep = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) state_next = ST_FB_MUL;
      end
      ST_FB_MUL: begin
        cmd.fb_mul = 1'b1;
        state_next = ST_X_SAT;
      end
      ST_X_SAT: begin
        cmd.x_sat = 1'b1;
        state_next = ST_Y_MUL;
      end
      ST_Y_MUL: begin
        cmd.y_mul = 1'b1;
        state_next = ST_Y_SAT;
      end
      ST_Y_SAT: begin
        cmd.y_sat = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_fire) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/foapf_datapath.sv
`default_nettype none
module foapf_datapath
  import foapf_pkg::*;
#(
  parameter int TRIG_ITERATIONS = 20
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire cmd_t                          cmd,
  input  wire logic [RATE_W-1:0]             sample_rate_hz,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
  input  wire logic [FREQ_W-1:0]             cutoff_freq,
  input  wire logic signed [GAIN_W-1:0]      feedback_gain,
  output status_t                            status,
  output logic signed [SAMPLE_BITS-1:0]      sample_out
);

  localparam int SB = SAMPLE_BITS;
  localparam int IT = (TRIG_ITERATIONS > 32) ? 32 : TRIG_ITERATIONS;
  localparam int DEN_W = RATE_W + 4;
  // PI_Q30 * fc fits in 32+FREQ_W bits; restoring division one bit per cycle
  localparam int NUMA_W = 32 + FREQ_W;
  localparam int ACNT_W = $clog2(NUMA_W + 1);
  localparam int PROD_W = SB + ALPHA_W + 1;
  localparam logic signed [SB-1:0] SAT_HI = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] SAT_LO = {1'b1, {(SB-1){1'b0}}};
  localparam logic signed [ANGLE_W-1:0] ONE_Q30 = 34'sd1073741824;
  localparam logic signed [ALPHA_W-1:0] A_MAX = 24'sd4194304;

  logic signed [SB-1:0] prev_x, prev_y;
  logic signed [SB-1:0] s_reg;
  logic signed [GAIN_W-1:0] fb_reg;
  logic [DEN_W-1:0] aden;
  logic [NUMA_W-1:0] anum;
  logic [DEN_W:0] arem;
  logic [ACNT_W-1:0] acnt;

  logic signed [ANGLE_W-1:0] cx, cy, cz;
  logic [4:0] ci;

  logic [QUO_W-1:0] dq;
  logic [ANGLE_W+22:0] dnum;
  logic [ANGLE_W:0] dden;
  logic [ANGLE_W+1:0] drem;
  logic dneg;
  logic [5:0] dcnt;

  logic signed [ALPHA_W-1:0] alpha;
  logic signed [PROD_W-1:0] prod;
  logic signed [SB:0] x_diff;
  logic signed [SB-1:0] x_sat;

  logic [RATE_W-1:0] fs_eff;
  logic [RATE_W+2:0] lim;
  logic [FREQ_W-1:0] fc_clamp;
  logic [DEN_W:0] arem_sh;
  logic signed [ANGLE_W-1:0] dx, dy;
  logic signed [ANGLE_W:0] sum_c, dif_c;
  logic [ANGLE_W+1:0] drem_sh;
  logic signed [SB+2:0] fb_term;
  logic signed [SB+2:0] x_wide;
  logic signed [SB+2:0] y_term;
  logic signed [SB+2:0] y_wide;
  logic signed [QUO_W:0] q_signed;
  logic [QUO_W-1:0] q_mag;

  function automatic logic signed [SB-1:0] sample_out_next(input logic signed [SB+2:0] v);
    if (v > (SB+3)'(SAT_HI)) sample_out_next = SAT_HI;
    else if (v < (SB+3)'(SAT_LO)) sample_out_next = SAT_LO;
    else sample_out_next = SB'(v);
  endfunction

  always_comb begin
    fs_eff = (sample_rate_hz == '0) ? RATE_W'(1) : sample_rate_hz;
    lim = {fs_eff, 3'b000};
    fc_clamp = (cutoff_freq > lim) ? lim : cutoff_freq;
    arem_sh = {arem[DEN_W-1:0], anum[NUMA_W-1]};
    dx = cy >>> ci;
    dy = cx >>> ci;
    sum_c = cy + cx;
    dif_c = cy - cx;
    drem_sh = {drem[ANGLE_W:0], dnum[ANGLE_W+22]};
    fb_term = (SB+3)'((prod + PROD_W'(1 <<< 13)) >>> 14);
    x_wide = (SB+3)'(s_reg) + fb_term;
    y_term = (SB+3)'((prod + PROD_W'(1 <<< 21)) >>> 22);
    y_wide = y_term + (SB+3)'(prev_x);
    q_mag = dq;
    q_signed = dneg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
  end

  assign status = '{angle_done: (acnt == ACNT_W'(NUMA_W - 1)),
                    cordic_done: (ci == 5'(IT - 1)),
                    div_done: (dcnt == 6'd56)};

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x <= '0;
      prev_y <= '0;
    end else begin
      if (cmd.y_sat) prev_x <= x_sat;
      if (cmd.y_sat) prev_y <= sample_out_next(y_wide);
    end
  end

  assign sample_out = prev_y;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      s_reg <= sample_in;
      fb_reg <= feedback_gain;
      aden <= {fs_eff, 4'b0000};
      anum <= NUMA_W'(PI_Q30) * NUMA_W'(fc_clamp);
      arem <= '0;
      acnt <= '0;
    end
    if (cmd.angle_step) begin
      if (arem_sh >= {1'b0, aden}) begin
        arem <= arem_sh - {1'b0, aden};
        anum <= {anum[NUMA_W-2:0], 1'b1};
      end else begin
        arem <= arem_sh;
        anum <= {anum[NUMA_W-2:0], 1'b0};
      end
      acnt <= acnt + ACNT_W'(1);
      if (status.angle_done) begin
        cx <= ONE_Q30;
        cy <= '0;
        cz <= $signed(ANGLE_W'({anum[NUMA_W-2:0], arem_sh >= {1'b0, aden}}));
        ci <= '0;
      end
    end
    if (cmd.cordic_step) begin
      if (!cz[ANGLE_W-1]) begin
        cx <= cx - dx;
        cy <= cy + dy;
        cz <= cz - $signed(atan_q30(ci));
      end else begin
        cx <= cx + dx;
        cy <= cy - dy;
        cz <= cz + $signed(atan_q30(ci));
      end
      ci <= ci + 5'd1;
    end
    if (cmd.div_prep) begin
      dneg <= dif_c[ANGLE_W];
      dnum <= {1'b0, (dif_c[ANGLE_W] ? ANGLE_W'(-dif_c) : ANGLE_W'(dif_c)), 22'd0};
      dden <= (sum_c <= 0) ? (ANGLE_W+1)'(1) : $unsigned(sum_c);
      drem <= '0;
      dq <= '0;
      dcnt <= '0;
    end
    if (cmd.div_step) begin
      if (drem_sh >= {1'b0, dden}) begin
        drem <= drem_sh - {1'b0, dden};
        dq <= {dq[QUO_W-2:0], 1'b1} |
          (dq[QUO_W-1:QUO_W-2] != 2'b00 ? {QUO_W{1'b1}} : '0);
      end else begin
        drem <= drem_sh;
        dq <= {dq[QUO_W-2:0], 1'b0} |
          (dq[QUO_W-1:QUO_W-2] != 2'b00 ? {QUO_W{1'b1}} : '0);
      end
      dnum <= {dnum[ANGLE_W+21:0], 1'b0};
      dcnt <= dcnt + 6'd1;
    end
    if (cmd.fb_mul) begin
      if ($signed(q_signed) > (QUO_W+1)'(A_MAX)) alpha <= A_MAX;
      else if ($signed(q_signed) < -(QUO_W+1)'(A_MAX)) alpha <= -A_MAX;
      else alpha <= ALPHA_W'(q_signed);
      prod <= PROD_W'(fb_reg * prev_y);
    end
    if (cmd.x_sat) begin
      x_sat <= sample_out_next(x_wide);
      x_diff <= sample_out_next(x_wide) - prev_y;
    end
    if (cmd.y_mul) prod <= PROD_W'(alpha * x_diff);
  end

endmodule
`default_nettype wire

FILE: rtl/first_order_allpass_with_feedback_core.sv
`default_nettype none
// First-order allpass with output feedback. One sample per transfer; the output
// is valid after the input transfer has passed a restoring divide for the
// angle, TRIG_ITERATIONS CORDIC steps, a setup step and a restoring divide for
// alpha, then the feedback multiply, x saturate, y multiply and y saturate
// steps. One item is in flight at a time; the next input is taken no earlier
// than the cycle after the output transfer. s_tdata: sample_in[23:0],
// cutoff_freq[44:24], feedback_gain[60:45]. The sample rate register is
// written through cfg_we.
module first_order_allpass_with_feedback_core
  import foapf_pkg::*;
#(
  parameter int TRIG_ITERATIONS = 20
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [17:0] cfg_wdata,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // sample_in, cutoff_freq, feedback_gain
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata    // sample_out
);

  localparam int SB = SAMPLE_BITS;
  logic [RATE_W-1:0] sample_rate_hz;
  cmd_t cmd;
  status_t status;
  logic busy;
  logic signed [SB-1:0] y;

  always_ff @(posedge clk) begin
    if (rst) sample_rate_hz <= RATE_W'(48000);
    else if (cfg_we) sample_rate_hz <= cfg_wdata;
  end

  assign s_tready = !busy;

  foapf_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_fire(s_tvalid && s_tready),
    .out_fire(m_tvalid && m_tready),
    .status(status), .cmd(cmd), .busy(busy), .out_valid(m_tvalid)
  );

  foapf_datapath #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sample_rate_hz(sample_rate_hz),
    .sample_in(s_tdata[SB-1:0]),
    .cutoff_freq(s_tdata[SB+FREQ_W-1:SB]),
    .feedback_gain(s_tdata[SB+FREQ_W+GAIN_W-1:SB+FREQ_W]),
    .status(status), .sample_out(y)
  );

  assign m_tdata = unsigned'(y);

endmodule
`default_nettype wire
